// ===== sv/dlfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfr_pkg
// shared types and constants of the display link frame responder
// ----------------------------------------------------------------------------
package dlfr_pkg;

   localparam int RX_FRAME_BYTES = 13;
   localparam int STORE_DEPTH    = RX_FRAME_BYTES - 1;
   localparam int STORE_AW       = $clog2(STORE_DEPTH);
   localparam int CNT_W          = $clog2(RX_FRAME_BYTES);
   localparam int REPLY_BYTES    = 12;
   localparam int REPLY_IW       = $clog2(REPLY_BYTES);
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [7:0] TRAILER_HI    = 8'h32;
   localparam logic [7:0] TRAILER_LO    = 8'h0E;
   localparam logic [7:0] REPLY_HEADER  = 8'h41;
   localparam logic [7:0] REPLY_MARKER  = 8'h24;
   localparam logic [7:0] TEMP_OFFSET   = 8'd15;
   localparam logic [6:0] SPEED_OFFSET  = 7'd10;
   localparam logic [7:0] SPEED_MASK    = 8'hF8;
   localparam logic [7:0] SPEED_HI_MASK = 8'h20;
   localparam logic [7:0] WHEEL_MASK    = 8'hC0;

   // floor(2^16 / 7), quotient estimate is exact or one low
   localparam logic [13:0] DIV7_RECIP   = 14'd9362;
   localparam logic [2:0]  DIV7         = 3'd7;

   // register indexes
   localparam logic [2:0] REG_DRIVE_POWER    = 3'd0;
   localparam logic [2:0] REG_WHEEL_PERIOD   = 3'd1;
   localparam logic [2:0] REG_ERROR_CODE     = 3'd2;
   localparam logic [2:0] REG_BATTERY        = 3'd3;
   localparam logic [2:0] REG_THROTTLE_ANIM  = 3'd4;
   localparam logic [2:0] REG_CRUISE         = 3'd5;
   localparam logic [2:0] REG_ASSIST         = 3'd6;
   localparam logic [2:0] REG_MOTOR_TEMP     = 3'd7;

   typedef struct packed {
      logic [15:0] drive_power;
      logic [15:0] wheel_period;
      logic [7:0]  error_code;
      logic [7:0]  battery_display;
      logic        show_throttle_anim;
      logic        show_cruise;
      logic        show_pedal_icon;
      logic [7:0]  motor_temp;
   } cfg_type;

   typedef struct packed {
      logic       headlight_on;
      logic [2:0] assist_step;
      logic [6:0] speed_limit;
      logic [4:0] wheel_size_code;
      logic [2:0] pulses_per_rev;
      logic [7:0] power_monitor;
      logic [7:0] motor_characteristic;
      logic [6:0] pas_config;
      logic [9:0] motor_config;
   } settings_type;

endpackage

// ===== sv/dlfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfr_front
// counts received bytes into frames, checks the trailer and unpacks settings
// ----------------------------------------------------------------------------
module dlfr_front import dlfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [7:0]   rx_byte,
   output logic         q_push,
   output settings_type q_data,
   input  logic         q_full
);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       store_ff [STORE_DEPTH];
   logic             accept;
   logic             closing;
   logic [7:0]       b0, b1, b2, b3, b4, b6, b7, b8;

   assign closing = (cnt_ff == CNT_W'(STORE_DEPTH));
   assign full    = closing && q_full;
   assign accept  = push && !full;
   assign q_push  = accept && closing && (store_ff[STORE_DEPTH-1] == TRAILER_HI)
                    && (rx_byte == TRAILER_LO);

   assign b0 = store_ff[0];
   assign b1 = store_ff[1];
   assign b2 = store_ff[2];
   assign b3 = store_ff[3];
   assign b4 = store_ff[4];
   assign b6 = store_ff[6];
   assign b7 = store_ff[7];
   assign b8 = store_ff[8];

   always_comb begin
      q_data.power_monitor        = b0;
      q_data.headlight_on         = b1[7];
      q_data.assist_step          = b1[2:0];
      q_data.speed_limit          = (7'((b2 & SPEED_MASK) >> 3) | 7'(b4 & SPEED_HI_MASK))
                                    + SPEED_OFFSET;
      q_data.wheel_size_code      = {b2[2:0], 2'((b4 & WHEEL_MASK) >> 6)};
      q_data.pulses_per_rev       = b4[2:0];
      q_data.motor_characteristic = b3;
      q_data.pas_config           = {b7[6:5], b6[5:3], b4[4], b4[3]};
      q_data.motor_config         = {b8[7:5], b7[3:0], b6[2:0]};
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (closing) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !closing) begin
         store_ff[cnt_ff[STORE_AW-1:0]] <= rx_byte;
      end
   end

endmodule

// ===== sv/dlfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfr_queue
// short queue of decoded frame settings between front and back
// ----------------------------------------------------------------------------
module dlfr_queue import dlfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  settings_type push_data,
   output logic         full,
   input  logic         pop,
   output settings_type pop_data,
   output logic         valid
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   settings_type       mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]        cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full     = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/dlfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfr_back
// plays out the 12-byte reply for each decoded frame
// ----------------------------------------------------------------------------
module dlfr_back import dlfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         q_valid,
   input  settings_type q_data,
   output logic         q_pop,
   output logic         empty,
   input  logic         pop,
   output logic [7:0]   tx_byte,
   output logic         tx_last,
   output settings_type settings
);

   settings_type         cur_ff, cur_in;
   logic                 busy_ff, busy_in;
   logic [REPLY_IW-1:0]  idx_ff, idx_in;
   logic                 fire, load;

   // power / 7 over three registered steps
   logic [15:0] pw_ff, pw_q_ff;
   logic [29:0] prod_ff;
   logic [13:0] q_est;
   logic [16:0] rem;
   logic [7:0]  power_div_ff, power_div_in;

   logic [7:0]  flags, temp_adj, check;

   assign q_est = prod_ff[29:16];
   assign rem   = {1'b0, pw_q_ff} - 17'({q_est, 3'b000} - {3'b000, q_est});

   always_comb begin
      if (rem >= 17'(DIV7)) begin
         power_div_in = q_est[7:0] + 8'd1;
      end else begin
         power_div_in = q_est[7:0];
      end
   end

   always_ff @(posedge clock) begin
      pw_ff        <= cfg.drive_power;
      prod_ff      <= 30'(pw_ff * DIV7_RECIP);
      pw_q_ff      <= pw_ff;
      power_div_ff <= power_div_in;
   end

   assign flags    = {3'b000, cfg.show_pedal_icon, cfg.show_cruise, 2'b00,
                      cfg.show_throttle_anim};
   assign temp_adj = cfg.motor_temp - TEMP_OFFSET;
   assign check    = cfg.battery_display ^ REPLY_MARKER ^ cfg.wheel_period[15:8]
                     ^ cfg.wheel_period[7:0] ^ cfg.error_code ^ flags ^ power_div_ff
                     ^ temp_adj;

   assign empty    = !busy_ff;
   assign tx_last  = (idx_ff == REPLY_IW'(REPLY_BYTES - 1));
   assign settings = cur_ff;
   assign fire     = busy_ff && pop;
   assign load     = !busy_ff || (fire && tx_last);
   assign q_pop    = load && q_valid;

   always_comb begin
      case (idx_ff)
         4'd0:    tx_byte = REPLY_HEADER;
         4'd1:    tx_byte = cfg.battery_display;
         4'd2:    tx_byte = REPLY_MARKER;
         4'd3:    tx_byte = cfg.wheel_period[15:8];
         4'd4:    tx_byte = cfg.wheel_period[7:0];
         4'd5:    tx_byte = cfg.error_code;
         4'd6:    tx_byte = check;
         4'd7:    tx_byte = flags;
         4'd8:    tx_byte = power_div_ff;
         4'd9:    tx_byte = temp_adj;
         default: tx_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      if (load) begin
         busy_in = q_valid;
         idx_in  = '0;
         cur_in  = q_data;
      end else if (fire) begin
         idx_in  = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== sv/display_link_frame_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_link_frame_responder
// Takes one received byte per clock cycle and counts bytes into 13-byte
// frames. A frame with the 0x32 0x0E trailer is decoded on its last byte and
// queued (two frames deep); the reply side then delivers its 12 reply bytes
// one per cycle while pop is high, each carrying the frame's decoded
// settings. Input stalls only on the closing byte of a frame while the reply
// queue is full, so the reply side sets the sustained rate under
// backpressure.
// ----------------------------------------------------------------------------
module display_link_frame_responder import dlfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   // reply channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic        rsp_headlight_on,
   output logic [2:0]  rsp_assist_step,
   output logic [6:0]  rsp_speed_limit,
   output logic [4:0]  rsp_wheel_size_code,
   output logic [2:0]  rsp_pulses_per_rev,
   output logic [7:0]  rsp_power_monitor,
   output logic [7:0]  rsp_motor_characteristic,
   output logic [6:0]  rsp_pas_config,
   output logic [9:0]  rsp_motor_config,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type      cfg_ff, cfg_in;
   logic         wr_en;
   logic [2:0]   reg_idx;
   logic         q_push, q_full, q_pop, q_valid;
   settings_type q_in_data, q_out_data, cur;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_DRIVE_POWER:   cfg_in.drive_power        = pwdata[15:0];
            REG_WHEEL_PERIOD:  cfg_in.wheel_period       = pwdata[15:0];
            REG_ERROR_CODE:    cfg_in.error_code         = pwdata[7:0];
            REG_BATTERY:       cfg_in.battery_display    = pwdata[7:0];
            REG_THROTTLE_ANIM: cfg_in.show_throttle_anim = pwdata[0];
            REG_CRUISE:        cfg_in.show_cruise        = pwdata[0];
            REG_ASSIST:        cfg_in.show_pedal_icon    = pwdata[0];
            REG_MOTOR_TEMP:    cfg_in.motor_temp         = pwdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DRIVE_POWER:   prdata = {16'h0000, cfg_ff.drive_power};
         REG_WHEEL_PERIOD:  prdata = {16'h0000, cfg_ff.wheel_period};
         REG_ERROR_CODE:    prdata = {24'h000000, cfg_ff.error_code};
         REG_BATTERY:       prdata = {24'h000000, cfg_ff.battery_display};
         REG_THROTTLE_ANIM: prdata = {31'h0, cfg_ff.show_throttle_anim};
         REG_CRUISE:        prdata = {31'h0, cfg_ff.show_cruise};
         REG_ASSIST:        prdata = {31'h0, cfg_ff.show_pedal_icon};
         REG_MOTOR_TEMP:    prdata = {24'h000000, cfg_ff.motor_temp};
         default:           prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_power        <= 16'h0000;
         cfg_ff.wheel_period       <= 16'hFFFF;
         cfg_ff.error_code         <= 8'h00;
         cfg_ff.battery_display    <= 8'h00;
         cfg_ff.show_throttle_anim <= 1'b0;
         cfg_ff.show_cruise        <= 1'b0;
         cfg_ff.show_pedal_icon    <= 1'b0;
         cfg_ff.motor_temp         <= 8'd23;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlfr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .rx_byte (req_rx_byte),
      .q_push  (q_push),
      .q_data  (q_in_data),
      .q_full  (q_full)
   );

   dlfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .valid     (q_valid)
   );

   dlfr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .tx_byte  (rsp_tx_byte),
      .tx_last  (rsp_tx_last),
      .settings (cur)
   );

   assign rsp_headlight_on         = cur.headlight_on;
   assign rsp_assist_step          = cur.assist_step;
   assign rsp_speed_limit          = cur.speed_limit;
   assign rsp_wheel_size_code      = cur.wheel_size_code;
   assign rsp_pulses_per_rev       = cur.pulses_per_rev;
   assign rsp_power_monitor        = cur.power_monitor;
   assign rsp_motor_characteristic = cur.motor_characteristic;
   assign rsp_pas_config           = cur.pas_config;
   assign rsp_motor_config         = cur.motor_config;

   // a reply burst is never cut short
   a_burst_whole: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_tx_last) |=> !empty)
      else $error("reply burst broken before its last byte");

   // every new burst opens with the header byte
   a_burst_header: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && rsp_tx_last) |=> (empty || rsp_tx_byte == REPLY_HEADER))
      else $error("reply burst without header byte");

   // decoded settings hold for the whole burst
   a_settings_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_tx_last) |=> ($stable(rsp_speed_limit)
         && $stable(rsp_motor_config) && $stable(rsp_pas_config)))
      else $error("settings changed within a reply burst");

   // the last byte of a reply is a zero byte
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_tx_last) |-> (rsp_tx_byte == 8'h00))
      else $error("last reply byte not zero");

endmodule

// ===== verif/tb_display_link_frame_responder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_display_link_frame_responder
// Feeds received display bytes through the request queue. A frame with the
// 0x32 0x0E trailer must produce the 12-byte reply together with the decoded
// settings. Each reply byte is checked field by field against an in-bench
// model of the byte counter, the settings decode and the reply build. The
// registers are set between phases over the register port and read back.
// Random gaps on both queues, plus one long stall on the reply side while
// requests keep coming.
// ----------------------------------------------------------------------------
module tb_display_link_frame_responder;
   import dlfr_pkg::*;

   localparam int CLK_PERIOD     = 12;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 480;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TARGET_ITEMS   = 380;

   typedef enum {FRAME_GOOD, FRAME_BAD_HI, FRAME_BAD_LO, FRAME_BAD_BOTH} frame_kind_type;

   typedef struct {
      logic [7:0]   tx_byte;
      logic         tx_last;
      settings_type settings;
   } reply_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_headlight_on;
   logic [2:0]  rsp_assist_step;
   logic [6:0]  rsp_speed_limit;
   logic [4:0]  rsp_wheel_size_code;
   logic [2:0]  rsp_pulses_per_rev;
   logic [7:0]  rsp_power_monitor;
   logic [7:0]  rsp_motor_characteristic;
   logic [6:0]  rsp_pas_config;
   logic [9:0]  rsp_motor_config;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   display_link_frame_responder dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_tx_last(rsp_tx_last),
      .rsp_headlight_on(rsp_headlight_on),
      .rsp_assist_step(rsp_assist_step),
      .rsp_speed_limit(rsp_speed_limit),
      .rsp_wheel_size_code(rsp_wheel_size_code),
      .rsp_pulses_per_rev(rsp_pulses_per_rev),
      .rsp_power_monitor(rsp_power_monitor),
      .rsp_motor_characteristic(rsp_motor_characteristic),
      .rsp_pas_config(rsp_pas_config),
      .rsp_motor_config(rsp_motor_config),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // model state
   cfg_type        cfg_model;
   settings_type   settings_model;
   logic [7:0]     frame_bytes [STORE_DEPTH];
   int unsigned    rx_count = 0;
   reply_byte_type expected_reply [$];

   logic [7:0]   rx_feed [$];
   int unsigned  items_queued = 0;
   int unsigned  errors = 0;
   bit           rx_quiet = 1'b0;
   bit           rsp_quiet = 1'b0;
   bit           hold_armed = 1'b0;
   int unsigned  rx_gap = 0;
   int unsigned  rsp_stall = 0;
   int unsigned  hold_left = 0;
   int unsigned  quiet_cycles = 0;

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic int unsigned draw_gap(input bit quiet);
      int unsigned r;
      r = $urandom_range(99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void set_register(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         REG_DRIVE_POWER:   cfg_model.drive_power        = v[15:0];
         REG_WHEEL_PERIOD:  cfg_model.wheel_period       = v[15:0];
         REG_ERROR_CODE:    cfg_model.error_code         = v[7:0];
         REG_BATTERY:       cfg_model.battery_display    = v[7:0];
         REG_THROTTLE_ANIM: cfg_model.show_throttle_anim = v[0];
         REG_CRUISE:        cfg_model.show_cruise        = v[0];
         REG_ASSIST:        cfg_model.show_pedal_icon    = v[0];
         REG_MOTOR_TEMP:    cfg_model.motor_temp         = v[7:0];
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] register_value(input logic [2:0] idx);
      case (idx)
         REG_DRIVE_POWER:   return {16'h0, cfg_model.drive_power};
         REG_WHEEL_PERIOD:  return {16'h0, cfg_model.wheel_period};
         REG_ERROR_CODE:    return {24'h0, cfg_model.error_code};
         REG_BATTERY:       return {24'h0, cfg_model.battery_display};
         REG_THROTTLE_ANIM: return {31'h0, cfg_model.show_throttle_anim};
         REG_CRUISE:        return {31'h0, cfg_model.show_cruise};
         REG_ASSIST:        return {31'h0, cfg_model.show_pedal_icon};
         default:           return {24'h0, cfg_model.motor_temp};
      endcase
   endfunction

   // byte counter, settings decode and reply build
   function automatic void take_display_byte(input logic [7:0] rx);
      logic [7:0]     reply [REPLY_BYTES];
      logic [7:0]     speed_raw;
      logic [15:0]    power_div;
      reply_byte_type rb;
      if (rx_count < STORE_DEPTH) begin
         frame_bytes[rx_count] = rx;
         rx_count++;
         return;
      end
      rx_count = 0;
      if (frame_bytes[STORE_DEPTH - 1] != TRAILER_HI || rx != TRAILER_LO) return;

      speed_raw = ((frame_bytes[2] & SPEED_MASK) >> 3) | (frame_bytes[4] & SPEED_HI_MASK);
      settings_model.power_monitor        = frame_bytes[0];
      settings_model.headlight_on         = frame_bytes[1][7];
      settings_model.assist_step          = frame_bytes[1][2:0];
      settings_model.speed_limit          = speed_raw[6:0] + SPEED_OFFSET;
      settings_model.wheel_size_code      = {frame_bytes[2][2:0], frame_bytes[4][7:6]};
      settings_model.pulses_per_rev       = frame_bytes[4][2:0];
      settings_model.motor_characteristic = frame_bytes[3];
      settings_model.pas_config           = {frame_bytes[7][6:5], frame_bytes[6][5:3],
                                             frame_bytes[4][4], frame_bytes[4][3]};
      settings_model.motor_config         = {frame_bytes[8][7:5], frame_bytes[7][3:0],
                                             frame_bytes[6][2:0]};

      power_div = cfg_model.drive_power / 16'd7;
      reply[0]  = REPLY_HEADER;
      reply[1]  = cfg_model.battery_display;
      reply[2]  = REPLY_MARKER;
      reply[3]  = cfg_model.wheel_period[15:8];
      reply[4]  = cfg_model.wheel_period[7:0];
      reply[5]  = cfg_model.error_code;
      reply[7]  = {3'b000, cfg_model.show_pedal_icon, cfg_model.show_cruise, 2'b00,
                   cfg_model.show_throttle_anim};
      reply[8]  = power_div[7:0];
      reply[9]  = cfg_model.motor_temp - TEMP_OFFSET;
      reply[10] = 8'h00;
      reply[11] = 8'h00;
      reply[6]  = reply[1] ^ reply[2] ^ reply[3] ^ reply[4] ^ reply[5]
                ^ reply[7] ^ reply[8] ^ reply[9];

      for (int k = 0; k < REPLY_BYTES; k++) begin
         rb.tx_byte  = reply[k];
         rb.tx_last  = (k == REPLY_BYTES - 1);
         rb.settings = settings_model;
         expected_reply.push_back(rb);
      end
   endfunction

   // request side
   always @(posedge clock) begin : rx_driver
      if (reset) begin
         push <= 1'b0;
         rx_gap = 0;
      end else begin
         if (push && !full) begin
            rx_feed.delete(0);
            take_display_byte(req_rx_byte);
            rx_gap = draw_gap(rx_quiet);
         end
         if (push && full) begin
            // keep offering the same request
         end else if (rx_gap > 0) begin
            rx_gap--;
            push <= 1'b0;
         end else if (rx_feed.size() != 0) begin
            push <= 1'b1;
            req_rx_byte <= rx_feed[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // reply side
   always @(posedge clock) begin : reply_monitor
      reply_byte_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_reply.size() == 0) begin
               $error("reply byte 0x%0h with nothing expected", rsp_tx_byte);
               errors++;
            end else begin
               want = expected_reply.pop_front();
               check_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
               check_field("tx_last", 32'(want.tx_last), 32'(rsp_tx_last));
               check_field("headlight_on", 32'(want.settings.headlight_on),
                           32'(rsp_headlight_on));
               check_field("assist_step", 32'(want.settings.assist_step),
                           32'(rsp_assist_step));
               check_field("speed_limit", 32'(want.settings.speed_limit),
                           32'(rsp_speed_limit));
               check_field("wheel_size_code", 32'(want.settings.wheel_size_code),
                           32'(rsp_wheel_size_code));
               check_field("pulses_per_rev", 32'(want.settings.pulses_per_rev),
                           32'(rsp_pulses_per_rev));
               check_field("power_monitor", 32'(want.settings.power_monitor),
                           32'(rsp_power_monitor));
               check_field("motor_characteristic", 32'(want.settings.motor_characteristic),
                           32'(rsp_motor_characteristic));
               check_field("pas_config", 32'(want.settings.pas_config),
                           32'(rsp_pas_config));
               check_field("motor_config", 32'(want.settings.motor_config),
                           32'(rsp_motor_config));
            end
            rsp_stall = draw_gap(rsp_quiet);
         end
         if (hold_armed) begin
            hold_left = HOLD_CYCLES;
            hold_armed = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transfer anywhere
   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles = 0;
      end else if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic csr_write_verify(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] want;
      set_register(idx, value);
      want = register_value(idx);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("prdata", want, prdata);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic program_display(input logic [31:0] power, input logic [31:0] period,
                                  input logic [31:0] err, input logic [31:0] battery,
                                  input logic [31:0] anim, input logic [31:0] cruise,
                                  input logic [31:0] assist, input logic [31:0] temp);
      csr_write_verify(REG_DRIVE_POWER, power);
      csr_write_verify(REG_WHEEL_PERIOD, period);
      csr_write_verify(REG_ERROR_CODE, err);
      csr_write_verify(REG_BATTERY, battery);
      csr_write_verify(REG_THROTTLE_ANIM, anim);
      csr_write_verify(REG_CRUISE, cruise);
      csr_write_verify(REG_ASSIST, assist);
      csr_write_verify(REG_MOTOR_TEMP, temp);
      @(negedge clock);
   endtask

   function automatic logic [7:0] byte_except(input logic [7:0] avoid);
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == avoid);
      return v;
   endfunction

   task automatic queue_noise(input int unsigned n);
      for (int i = 0; i < n; i++) rx_feed.push_back(8'($urandom_range(255)));
      items_queued += n;
   endtask

   task automatic queue_frame(input frame_kind_type kind, input bit use_fill,
                              input logic [7:0] fill);
      for (int i = 0; i < STORE_DEPTH - 1; i++)
         rx_feed.push_back(use_fill ? fill : 8'($urandom_range(255)));
      case (kind)
         FRAME_GOOD: begin
            rx_feed.push_back(TRAILER_HI);
            rx_feed.push_back(TRAILER_LO);
         end
         FRAME_BAD_HI: begin
            rx_feed.push_back(byte_except(TRAILER_HI));
            rx_feed.push_back(TRAILER_LO);
         end
         FRAME_BAD_LO: begin
            rx_feed.push_back(TRAILER_HI);
            rx_feed.push_back(byte_except(TRAILER_LO));
         end
         default: begin
            rx_feed.push_back(byte_except(TRAILER_HI));
            rx_feed.push_back(8'($urandom_range(255)));
         end
      endcase
      items_queued += RX_FRAME_BYTES;
   endtask

   task automatic queue_mixed_traffic(input int unsigned segments);
      int unsigned r;
      int unsigned n;
      for (int s = 0; s < segments; s++) begin
         r = $urandom_range(99);
         if (r < 65) begin
            queue_frame(FRAME_GOOD, 1'b0, 8'h00);
         end else if (r < 72) begin
            queue_frame(FRAME_BAD_HI, 1'b0, 8'h00);
         end else if (r < 79) begin
            queue_frame(FRAME_BAD_LO, 1'b0, 8'h00);
         end else if (r < 85) begin
            queue_frame(FRAME_BAD_BOTH, 1'b0, 8'h00);
         end else begin
            // slip the frame boundary, then pad back into step
            n = $urandom_range(STORE_DEPTH, 1);
            queue_noise(n);
            queue_frame(FRAME_GOOD, 1'b0, 8'h00);
            queue_noise(RX_FRAME_BYTES - n);
         end
      end
   endtask

   task automatic wait_idle();
      while (rx_feed.size() != 0 || push || expected_reply.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [31:0] power;
      logic [31:0] temp;
      logic [15:0] power_picks [10];
      logic [7:0]  temp_picks [5];

      power_picks = '{16'd0, 16'd6, 16'd7, 16'd13, 16'd14, 16'd1791, 16'd1792,
                      16'd65533, 16'd65534, 16'd65535};
      temp_picks  = '{8'd0, 8'd14, 8'd15, 8'd16, 8'd255};

      cfg_model = '0;
      cfg_model.wheel_period = 16'hFFFF;
      cfg_model.motor_temp   = 8'd23;
      settings_model = '0;
      settings_model.assist_step = 3'd1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, all-ones and all-zeros frame content
      queue_frame(FRAME_GOOD, 1'b1, 8'hFF);
      queue_frame(FRAME_GOOD, 1'b1, 8'h00);
      wait_idle();

      // every register at its top, with spare upper bits set
      program_display('1, '1, '1, '1, '1, '1, '1, '1);
      queue_mixed_traffic(4);
      wait_idle();

      // every register at zero; long reply stall while requests keep coming
      program_display('0, '0, '0, '0, '0, '0, '0, '0);
      rx_quiet = 1'b1;
      hold_armed = 1'b1;
      for (int i = 0; i < 6; i++) queue_frame(FRAME_GOOD, 1'b0, 8'h00);
      wait_idle();

      while (items_queued < TARGET_ITEMS) begin
         power = ($urandom_range(2) == 0) ? $urandom() :
                 {16'($urandom_range(65535, 0)), power_picks[$urandom_range(9)]};
         temp  = ($urandom_range(2) == 0) ? $urandom() : {24'h0, temp_picks[$urandom_range(4)]};
         program_display(power, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), temp);
         rx_quiet  = ($urandom_range(3) == 0);
         rsp_quiet = ($urandom_range(3) == 0);
         queue_mixed_traffic($urandom_range(6, 3));
         wait_idle();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
